// ===== rtl/receive_byte_ring_fifo_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Receive byte ring FIFO assertion macros
// Shared property forms for the checker of the receive byte ring FIFO.
// ----------------------------------------------------------------------------
`ifndef RECEIVE_BYTE_RING_FIFO_UNIT_MACROS_SVH
`define RECEIVE_BYTE_RING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive byte ring FIFO package
// Sizes, request and status codes, and transaction types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  // Number of byte slots, from 2 to 127; the 7-bit fill level limits the top.
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = 7;
  localparam int BYTE_W     = 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_BURST = 2'd1,
    REQ_POP   = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_DONE     = 3'd0,
    STS_DATA     = 3'd1,
    STS_REFUSED  = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  req_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_data;
    logic [CNT_W-1:0]  fill_level;
    logic [2:0]        status;
    logic              last;
  } out_item_t;

  // Byte store access issued by the controller.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/rbf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Receive byte ring FIFO controller
// Holds head pointer and fill count, sequences byte store accesses and
// drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rbf_pkg::in_item_t         in_item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rbf_pkg::out_item_t             out_item,
  output rbf_pkg::ram_req_t              ram_req,
  input  wire logic [rbf_pkg::BYTE_W-1:0] ram_rdata
);

  import rbf_pkg::*;

  state_t           state_r,  state_nxt;
  logic [PTR_W-1:0] ptr_r,    ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r,  out_item_nxt;

  logic             out_free;
  logic [PTR_W-1:0] ptr_inc;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail_idx;

  assign out_free = !out_valid_r || out_ready;
  assign ptr_inc  = (ptr_r == LAST_PTR) ? '0 : ptr_r + 1'b1;

  // Head plus count stays below twice the depth, so one subtract wraps it.
  assign tail_sum = (PTR_W+1)'(ptr_r) + (PTR_W+1)'(count_r);
  assign tail_idx = (tail_sum >= (PTR_W+1)'(FIFO_DEPTH))
                  ? PTR_W'(tail_sum - (PTR_W+1)'(FIFO_DEPTH))
                  : PTR_W'(tail_sum);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ram_req       = '0;
    in_ready      = (state_r == ST_IDLE) && out_free;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_item.req_type)
            REQ_PUSH: begin
              out_valid_nxt = 1'b1;
              if (count_r == DEPTH_CNT) begin
                out_item_nxt = '{rd_data: '0, fill_level: count_r,
                                 status: STS_OVERFLOW, last: 1'b1};
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tail_idx;
                ram_req.wdata = in_item.in_byte;
                count_nxt     = count_r + 1'b1;
                out_item_nxt  = '{rd_data: '0, fill_level: count_r + 1'b1,
                                  status: STS_DONE, last: 1'b1};
              end
            end
            REQ_BURST: begin
              if (in_item.req_count > count_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{rd_data: '0, fill_level: count_r,
                                  status: STS_REFUSED, last: 1'b1};
              end else if (in_item.req_count == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{rd_data: '0, fill_level: count_r,
                                  status: STS_DONE, last: 1'b1};
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ptr_r;
                remain_nxt    = in_item.req_count;
                state_nxt     = ST_POP;
              end
            end
            REQ_POP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{rd_data: '0, fill_level: '0,
                                  status: STS_EMPTY, last: 1'b1};
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ptr_r;
                remain_nxt    = CNT_W'(1);
                state_nxt     = ST_POP;
              end
            end
            REQ_FLUSH: begin
              ptr_nxt       = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{rd_data: '0, fill_level: '0,
                                status: STS_DONE, last: 1'b1};
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
            end
          endcase
        end
      end
      ST_POP: begin
        // The read data holds until the output register can take it, and
        // the read of the following byte is issued as the current one leaves.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{rd_data: ram_rdata, fill_level: count_r - 1'b1,
                            status: STS_DATA, last: (remain_r == CNT_W'(1))};
          ptr_nxt       = ptr_inc;
          count_nxt     = count_r - 1'b1;
          if (remain_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = ptr_inc;
            remain_nxt    = remain_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/receive_byte_ring_fifo_unit.sv =====
// The receive byte ring FIFO keeps up to FIFO_DEPTH bytes in a byte store RAM
// with a registered read and answers one request per input transaction: push,
// burst pop, single pop or flush. Push, flush, a refused or zero-length burst
// and a pop from an empty FIFO return their result from the output register
// in the cycle after acceptance. A pop that removes bytes reads the store
// first, since the byte store read is registered, and then delivers one data
// transaction per cycle while the output is not stalled. No new request is
// taken until the last byte of a pop has entered the output register. A write
// is always visible to a read in a later cycle, so no forwarding path is
// needed.
`default_nettype none

module receive_byte_ring_fifo_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rbf_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rbf_pkg::out_item_t     out_item
);

  import rbf_pkg::*;

  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rdata;

  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  rbf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_byte_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/rbf_checker.sv =====
// ----------------------------------------------------------------------------
// Receive byte ring FIFO checker
// Port-level properties of the FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "receive_byte_ring_fifo_unit_macros.svh"

module rbf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire rbf_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rbf_pkg::out_item_t out_item
);

  import rbf_pkg::*;

  `RBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_item), "stalled output transaction changed")

  // A data transaction that is not the last one means the burst is still running.
  `RBF_ASSERT_SAME(a_burst_blocks_input, clk, rst_n,
    out_valid && !out_item.last, !in_ready,
    "request taken in the middle of a burst")

  `RBF_ASSERT_NEXT(a_flush_result, clk, rst_n,
    in_valid && in_ready && (in_item.req_type == REQ_FLUSH),
    out_valid && (out_item.fill_level == '0) && (out_item.status == STS_DONE),
    "flush did not report an empty FIFO")

  `RBF_ASSERT_NEXT(a_push_result, clk, rst_n,
    in_valid && in_ready && (in_item.req_type == REQ_PUSH),
    out_valid && out_item.last &&
    ((out_item.status == STS_DONE) || (out_item.status == STS_OVERFLOW)),
    "push result missing or wrong status")

endmodule

bind receive_byte_ring_fifo_unit rbf_checker u_rbf_checker (.*);

`default_nettype wire
